[hw/rtl/lbps_pkg.sv]
// Shared types and codes for the LED blink pattern slot block.
package lbps_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_SET   = 2'd3;

	// Pattern kinds held in a slot.
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_FATAL   = 3'd1;
	localparam logic [2:0] KIND_NOMOD   = 3'd2;
	localparam logic [2:0] KIND_ALIVE   = 3'd3;
	localparam logic [2:0] KIND_READING = 3'd4;
	localparam logic [2:0] KIND_STATUS  = 3'd5;

	// Outcome codes of a result.
	localparam logic [1:0] OUT_DONE     = 2'd0;
	localparam logic [1:0] OUT_DROPPED  = 2'd1;
	localparam logic [1:0] OUT_DISABLED = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_DISABLE_AFTER = 2'd0;
	localparam logic [1:0] REG_FATAL_PERIOD  = 2'd1;
	localparam logic [1:0] REG_NOMOD_PERIOD  = 2'd2;
	localparam logic [1:0] REG_STATUS_PERIOD = 2'd3;

	// Contents of one blink slot.
	typedef struct packed {
		logic [2:0]  pattern;
		logic [31:0] deadline;
		logic [7:0]  blinks;
	} slot_t;

	// Per-item controls seen by the slot unit.
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now;
		logic [2:0]  kind;
		logic [7:0]  count;
		logic [15:0] fatal_period;
		logic [15:0] nomod_period;
		logic [15:0] status_period;
	} step_ctl_t;

endpackage

[hw/rtl/led_blink_pattern_slots.sv]
// Top level of the LED blink pattern slot block: sequencer, slot store and config.
//
//  channel   signals                                           direction
//  -------   -----------------------------------------------   ---------
//  item      start, operation, now_ms, pattern_kind,           in
//            blink_count, level (busy is an output)
//  result    done, led_a, led_b, led_c, outcome                out
//  config    cfg_valid, cfg_index, cfg_data; cfg_ready is out   in
//
// Tick and clear walk the slots one per cycle through a single shared slot
// unit, visiting every slot; the result strobe is registered from the last
// step. A push stops at the first idle slot. Set-all and a disabled push
// finish without a walk. Reset clears all slots and LEDs at once; no sweep
// follows. Results cannot be stalled: done is high for one cycle.
module led_blink_pattern_slots #(
	parameter int SLOT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] now_ms,
	input  logic [2:0]  pattern_kind,
	input  logic [7:0]  blink_count,
	input  logic        level,
	output logic        done,
	output logic        led_a,
	output logic        led_b,
	output logic        led_c,
	output logic [1:0]  outcome,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import lbps_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       op_q;
	logic [31:0]      now_q;
	logic [2:0]       kind_q;
	logic [7:0]       count_q;
	logic [2:0]       led_q;
	logic [1:0]       outcome_q;
	logic             done_q;
	slot_t            slots_q [SLOT_COUNT];

	logic [31:0] disable_after_q;
	logic [15:0] fatal_period_q;
	logic [15:0] nomod_period_q;
	logic [15:0] status_period_q;

	logic      accept;
	logic      disabled;
	step_ctl_t ctl;
	slot_t     slot_cur;
	slot_t     slot_nxt;
	logic [2:0] led_nxt;
	logic      claimed;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign disabled  = (disable_after_q != 32'd0) && (now_ms > disable_after_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disable_after_q <= 32'd0;
			fatal_period_q  <= 16'd100;
			nomod_period_q  <= 16'd500;
			status_period_q <= 16'd200;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DISABLE_AFTER: disable_after_q <= cfg_data;
				REG_FATAL_PERIOD:  fatal_period_q  <= cfg_data[15:0];
				REG_NOMOD_PERIOD:  nomod_period_q  <= cfg_data[15:0];
				REG_STATUS_PERIOD: status_period_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Controls for the shared slot unit.
	always_comb begin
		ctl.op            = op_q;
		ctl.now           = now_q;
		ctl.kind          = kind_q;
		ctl.count         = count_q;
		ctl.fatal_period  = fatal_period_q;
		ctl.nomod_period  = nomod_period_q;
		ctl.status_period = status_period_q;
	end

	assign slot_cur = slots_q[idx_q];

	lbps_slot_unit u_slot_unit (
		.ctl      (ctl),
		.slot_in  (slot_cur),
		.led_in   (led_q),
		.slot_out (slot_nxt),
		.led_out  (led_nxt),
		.claimed  (claimed)
	);

	// Sequencer, slot store and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			op_q      <= OP_TICK;
			now_q     <= 32'd0;
			kind_q    <= KIND_NONE;
			count_q   <= 8'd0;
			led_q     <= 3'd0;
			outcome_q <= OUT_DONE;
			done_q    <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= operation;
						now_q   <= now_ms;
						kind_q  <= pattern_kind;
						count_q <= blink_count;
						idx_q   <= '0;
						if (operation == OP_SET) begin
							if (disabled) begin
								outcome_q <= OUT_DISABLED;
							end else begin
								led_q     <= {3{level}};
								outcome_q <= OUT_DONE;
							end
							done_q <= 1'b1;
						end else if (operation == OP_PUSH && disabled) begin
							outcome_q <= OUT_DISABLED;
							done_q    <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					slots_q[idx_q] <= slot_nxt;
					led_q          <= led_nxt;
					if (claimed || idx_q == LAST_IDX) begin
						state_q   <= ST_IDLE;
						done_q    <= 1'b1;
						outcome_q <= (op_q == OP_PUSH && !claimed) ? OUT_DROPPED : OUT_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign led_a   = led_q[0];
	assign led_b   = led_q[1];
	assign led_c   = led_q[2];
	assign outcome = outcome_q;

endmodule

[hw/rtl/lbps_slot_unit.sv]
// Shared slot unit: updates one slot and the LED levels for tick, push or clear.
module lbps_slot_unit (
	input  lbps_pkg::step_ctl_t ctl,
	input  lbps_pkg::slot_t     slot_in,
	input  logic [2:0]          led_in,
	output lbps_pkg::slot_t     slot_out,
	output logic [2:0]          led_out,
	output logic                claimed
);
	import lbps_pkg::*;

	logic        due;
	logic [15:0] period;
	logic [31:0] next_deadline;

	// One compare and one adder serve every slot in turn.
	assign due = slot_in.deadline < ctl.now;

	always_comb begin
		unique case (slot_in.pattern)
			KIND_FATAL: period = ctl.fatal_period;
			KIND_NOMOD: period = ctl.nomod_period;
			default:    period = ctl.status_period;
		endcase
	end

	assign next_deadline = ctl.now + {16'd0, period};

	// Slot update for the current operation.
	always_comb begin
		slot_out = slot_in;
		led_out  = led_in;
		claimed  = 1'b0;
		unique case (ctl.op)
			OP_TICK: begin
				unique case (slot_in.pattern)
					KIND_FATAL: begin
						if (due) begin
							led_out = {3{~led_in[0]}};
							slot_out.deadline = next_deadline;
						end
					end
					KIND_NOMOD: begin
						if (due) begin
							led_out[0] = ~led_in[0];
							slot_out.deadline = next_deadline;
						end
					end
					KIND_READING: begin
						led_out[1] = 1'b1;
					end
					KIND_STATUS: begin
						if (due) begin
							if (led_in[2]) begin
								led_out[2] = 1'b0;
								if (slot_in.blinks > 8'd1) begin
									slot_out.blinks = slot_in.blinks - 8'd1;
									slot_out.deadline = next_deadline;
								end else begin
									slot_out.pattern = KIND_NONE;
								end
							end else begin
								led_out[2] = 1'b1;
								slot_out.deadline = next_deadline;
							end
						end
					end
					default: begin
					end
				endcase
			end
			OP_PUSH: begin
				if (slot_in.pattern == KIND_NONE) begin
					slot_out.pattern  = ctl.kind;
					slot_out.deadline = 32'd0;
					slot_out.blinks   = ctl.count;
					claimed = 1'b1;
				end
			end
			OP_CLEAR: begin
				if (slot_in.pattern == ctl.kind) begin
					if (slot_in.pattern == KIND_READING) begin
						led_out[1] = 1'b0;
					end
					slot_out.pattern = KIND_NONE;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LED blink pattern slot block: directed script, then random phases.
module tb;
	import lbps_pkg::*;

	localparam int SLOTS = 4;

	// Kinds with no pattern of their own; they only occupy a slot.
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	typedef struct packed {
		logic       a;
		logic       b;
		logic       c;
		logic [1:0] outcome;
	} led_result_t;

	// One line of the directed script: an item or a register write.
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  op;
		logic [31:0] now;
		logic [2:0]  kind;
		logic [7:0]  count;
		logic        level;
		logic        typed;
		led_result_t res;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [31:0] now_ms;
	logic [2:0]  pattern_kind;
	logic [7:0]  blink_count;
	logic        level;
	logic        done;
	logic        led_a;
	logic        led_b;
	logic        led_c;
	logic [1:0]  outcome;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// Hand-written result that travels with an item of the directed script.
	logic        typed_en;
	led_result_t typed_res;

	// Mirror of the LEDs, the slots and the registers.
	logic [2:0]  led_state;
	logic [2:0]  slot_kind [SLOTS];
	logic [31:0] slot_due  [SLOTS];
	logic [7:0]  slot_left [SLOTS];
	logic [31:0] hold_after_ms;
	logic [15:0] fatal_ms;
	logic [15:0] nomod_ms;
	logic [15:0] status_ms;

	led_result_t led_expect_q[$];
	script_row_t script_q[$];
	int          mismatches = 0;
	int          results_seen = 0;
	logic        calm;
	logic [31:0] clock_ms;

	led_blink_pattern_slots #(.SLOT_COUNT(SLOTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.now_ms       (now_ms),
		.pattern_kind (pattern_kind),
		.blink_count  (blink_count),
		.level        (level),
		.done         (done),
		.led_a        (led_a),
		.led_b        (led_b),
		.led_c        (led_c),
		.outcome      (outcome),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Applies one item to the mirrored state and returns the LED levels and outcome.
	function automatic led_result_t predict_step(input logic [1:0] op, input logic [31:0] now,
			input logic [2:0] kind, input logic [7:0] count, input logic lvl);
		led_result_t r;
		logic        held;
		logic        due;
		logic        placed;
		held = (hold_after_ms != 32'd0) && (now > hold_after_ms);
		r = '0;
		r.outcome = OUT_DONE;
		case (op)
			OP_TICK: begin
				// Slots act in index order; deadlines compare unsigned and strictly.
				for (int i = 0; i < SLOTS; i++) begin
					due = slot_due[i] < now;
					case (slot_kind[i])
						KIND_FATAL: begin
							if (due) begin
								led_state = {3{~led_state[0]}};
								slot_due[i] = now + 32'(fatal_ms);
							end
						end
						KIND_NOMOD: begin
							if (due) begin
								led_state[0] = ~led_state[0];
								slot_due[i] = now + 32'(nomod_ms);
							end
						end
						KIND_READING: begin
							led_state[1] = 1'b1;
						end
						KIND_STATUS: begin
							if (due && led_state[2]) begin
								led_state[2] = 1'b0;
								if (slot_left[i] > 8'd1) begin
									slot_left[i] = slot_left[i] - 8'd1;
									slot_due[i] = now + 32'(status_ms);
								end else begin
									slot_kind[i] = KIND_NONE;
								end
							end else if (due) begin
								led_state[2] = 1'b1;
								slot_due[i] = now + 32'(status_ms);
							end
						end
						default: begin
						end
					endcase
				end
			end
			OP_PUSH: begin
				if (held) begin
					r.outcome = OUT_DISABLED;
				end else begin
					placed = 1'b0;
					for (int i = 0; i < SLOTS; i++) begin
						if (!placed && slot_kind[i] == KIND_NONE) begin
							slot_kind[i] = kind;
							slot_due[i] = 32'd0;
							slot_left[i] = count;
							placed = 1'b1;
						end
					end
					if (!placed)
						r.outcome = OUT_DROPPED;
				end
			end
			OP_CLEAR: begin
				// Freeing a reading slot turns LED B off.
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_kind[i] == kind) begin
						if (kind == KIND_READING)
							led_state[1] = 1'b0;
						slot_kind[i] = KIND_NONE;
					end
				end
			end
			default: begin
				if (held)
					r.outcome = OUT_DISABLED;
				else
					led_state = {3{lvl}};
			end
		endcase
		r.a = led_state[0];
		r.b = led_state[1];
		r.c = led_state[2];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	// Result check, register mirror and item acceptance, in that order at each edge.
	always @(posedge clk) begin : result_monitor
		led_result_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (led_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no item outstanding",
						results_seen));
				end else begin
					want = led_expect_q.pop_front();
					if (led_a !== want.a)
						report_mismatch($sformatf("result %0d led_a %b, expected %b",
							results_seen, led_a, want.a));
					if (led_b !== want.b)
						report_mismatch($sformatf("result %0d led_b %b, expected %b",
							results_seen, led_b, want.b));
					if (led_c !== want.c)
						report_mismatch($sformatf("result %0d led_c %b, expected %b",
							results_seen, led_c, want.c));
					if (outcome !== want.outcome)
						report_mismatch($sformatf("result %0d outcome %0d, expected %0d",
							results_seen, outcome, want.outcome));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DISABLE_AFTER: hold_after_ms = cfg_data;
					REG_FATAL_PERIOD:  fatal_ms = cfg_data[15:0];
					REG_NOMOD_PERIOD:  nomod_ms = cfg_data[15:0];
					REG_STATUS_PERIOD: status_ms = cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				want = predict_step(operation, now_ms, pattern_kind, blink_count, level);
				if (typed_en)
					want = typed_res;
				led_expect_q.push_back(want);
			end
		end
	end

	task automatic add_item(input logic [1:0] op, input logic [31:0] now, input logic [2:0] kind,
			input logic [7:0] count, input logic lvl, input logic typed, input logic [2:0] abc,
			input logic [1:0] code);
		script_row_t row;
		row = '0;
		row.op = op;
		row.now = now;
		row.kind = kind;
		row.count = count;
		row.level = lvl;
		row.typed = typed;
		row.res = '{abc[2], abc[1], abc[0], code};
		script_q.push_back(row);
	endtask

	task automatic add_reg(input logic [1:0] idx, input logic [31:0] val);
		script_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		script_q.push_back(row);
	endtask

	// Presents one item, at times after a random gap (never when calm), and returns at the edge that takes it.
	task automatic send_item(input script_row_t row);
		cfg_valid <= 1'b0;
		if (!calm && $urandom_range(99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= row.op;
		now_ms <= row.now;
		pattern_kind <= row.kind;
		blink_count <= row.count;
		level <= row.level;
		typed_en <= row.typed;
		typed_res <= row.res;
		do @(posedge clk); while (busy);
	endtask

	// Leaves valid high; the next item or write decides what comes after.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (led_expect_q.size() != 0 || busy);
	endtask

	// Mostly a steadily advancing clock with random operations; a few stray timestamps.
	task automatic random_item();
		script_row_t row;
		int          pick;
		row = '0;
		clock_ms = clock_ms + 32'($urandom_range(0, 120));
		row.now = clock_ms;
		pick = $urandom_range(99);
		if (pick < 3)
			row.now = $urandom();
		else if (pick < 6)
			row.now = clock_ms - 32'($urandom_range(0, 2000));
		pick = $urandom_range(99);
		if (pick < 45)
			row.op = OP_TICK;
		else if (pick < 70)
			row.op = OP_PUSH;
		else if (pick < 85)
			row.op = OP_CLEAR;
		else
			row.op = OP_SET;
		if ($urandom_range(99) < 85)
			row.kind = 3'($urandom_range(KIND_FATAL, KIND_STATUS));
		else
			row.kind = 3'($urandom_range(KIND_NONE, KIND_SPARE7));
		if ($urandom_range(1) == 1)
			row.count = 8'($urandom_range(0, 6));
		else
			row.count = 8'($urandom_range(0, 255));
		row.level = 1'($urandom_range(1));
		send_item(row);
	endtask

	initial begin
		logic [31:0] hold_val;
		logic [15:0] fatal_val;
		logic [15:0] nomod_val;
		logic [15:0] status_val;
		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_TICK;
		now_ms <= '0;
		pattern_kind <= KIND_NONE;
		blink_count <= '0;
		level <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DISABLE_AFTER;
		cfg_data <= '0;
		typed_en <= 1'b0;
		typed_res <= '0;
		calm = 1'b0;
		clock_ms = 32'd10000;

		// Mirror starts from the reset state.
		led_state = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_kind[i] = KIND_NONE;
			slot_due[i] = '0;
			slot_left[i] = '0;
		end
		hold_after_ms = 32'd0;
		fatal_ms = 16'd100;
		nomod_ms = 16'd500;
		status_ms = 16'd200;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset state, set-all extremes, strict deadline, full pool.
		add_item(OP_TICK,  32'd0,          KIND_NONE,    8'd0,   1'b0, 1'b1, 3'b000, OUT_DONE);
		add_item(OP_SET,   32'hFFFF_FFFF,  KIND_NONE,    8'd0,   1'b1, 1'b1, 3'b111, OUT_DONE);
		add_item(OP_SET,   32'd5,          KIND_NONE,    8'd0,   1'b0, 1'b1, 3'b000, OUT_DONE);
		add_item(OP_PUSH,  32'd10,         KIND_FATAL,   8'd0,   1'b0, 1'b1, 3'b000, OUT_DONE);
		add_item(OP_TICK,  32'd0,          KIND_NONE,    8'd0,   1'b0, 1'b1, 3'b000, OUT_DONE);
		add_item(OP_TICK,  32'd1,          KIND_NONE,    8'd0,   1'b0, 1'b1, 3'b111, OUT_DONE);
		add_item(OP_PUSH,  32'd2,          KIND_NOMOD,   8'd255, 1'b0, 1'b1, 3'b111, OUT_DONE);
		add_item(OP_PUSH,  32'd3,          KIND_READING, 8'd0,   1'b0, 1'b1, 3'b111, OUT_DONE);
		add_item(OP_PUSH,  32'd4,          KIND_STATUS,  8'd1,   1'b0, 1'b1, 3'b111, OUT_DONE);
		add_item(OP_PUSH,  32'd5,          KIND_ALIVE,   8'd0,   1'b0, 1'b1, 3'b111, OUT_DROPPED);
		// Slot walk, reading clear, clear of idle, unnamed kinds, deadline wrap.
		add_item(OP_TICK,  32'd50,         KIND_NONE,    8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_CLEAR, 32'd60,         KIND_READING, 8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_CLEAR, 32'd61,         KIND_NONE,    8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_PUSH,  32'd62,         KIND_SPARE7,  8'd3,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_PUSH,  32'd63,         KIND_SPARE6,  8'hAA,  1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_TICK,  32'hFFFF_FFFF,  KIND_NONE,    8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_CLEAR, 32'd70,         KIND_SPARE7,  8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_CLEAR, 32'd71,         KIND_SPARE6,  8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_CLEAR, 32'd72,         KIND_FATAL,   8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_CLEAR, 32'd73,         KIND_NOMOD,   8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_PUSH,  32'd100,        KIND_STATUS,  8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		add_item(OP_TICK,  32'd200,        KIND_NONE,    8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);
		// Disable threshold is strict; tick still works past it.
		add_reg(REG_DISABLE_AFTER, 32'd1000);
		add_reg(REG_FATAL_PERIOD,  32'd0);
		add_reg(REG_NOMOD_PERIOD,  32'h0000_FFFF);
		add_reg(REG_STATUS_PERIOD, 32'h0000_FFFF);
		add_item(OP_SET,   32'd1000,       KIND_NONE,    8'd0,   1'b1, 1'b1, 3'b111, OUT_DONE);
		add_item(OP_PUSH,  32'd1001,       KIND_ALIVE,   8'd0,   1'b0, 1'b1, 3'b111, OUT_DISABLED);
		add_item(OP_SET,   32'hFFFF_FFFF,  KIND_NONE,    8'd0,   1'b0, 1'b1, 3'b111, OUT_DISABLED);
		add_item(OP_TICK,  32'd5000,       KIND_NONE,    8'd0,   1'b0, 1'b0, 3'b000, OUT_DONE);

		foreach (script_q[i]) begin
			if (script_q[i].is_cfg) begin
				if (i == 0 || !script_q[i - 1].is_cfg)
					wait_idle();
				write_reg(script_q[i].reg_idx, script_q[i].reg_val);
			end else begin
				send_item(script_q[i]);
			end
		end

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			if (phase == 3)
				clock_ms = 32'hFFFF_F000;
			fatal_val = 16'($urandom_range(0, 700));
			nomod_val = 16'($urandom_range(0, 700));
			status_val = 16'($urandom_range(0, 700));
			hold_val = clock_ms + 32'($urandom_range(500, 8000));
			case (phase)
				0: begin
					hold_val = 32'hFFFF_FFFF;
					fatal_val = 16'd0;
					nomod_val = 16'd0;
					status_val = 16'd0;
				end
				1: begin
					hold_val = 32'd0;
					fatal_val = 16'hFFFF;
					nomod_val = 16'hFFFF;
					status_val = 16'hFFFF;
				end
				2: begin
					fatal_val = 16'd1;
					nomod_val = 16'd1;
					status_val = 16'd1;
				end
				3: begin
					hold_val = 32'd0;
				end
				default: begin
				end
			endcase
			write_reg(REG_DISABLE_AFTER, hold_val);
			write_reg(REG_FATAL_PERIOD, {16'd0, fatal_val});
			write_reg(REG_NOMOD_PERIOD, {16'd0, nomod_val});
			write_reg(REG_STATUS_PERIOD, {16'd0, status_val});
			calm = (phase == 5);
			repeat (150) random_item();
		end

		wait_idle();
		repeat (2 * SLOTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#(5_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
hw/rtl/lbps_pkg.sv
hw/rtl/lbps_slot_unit.sv
hw/rtl/led_blink_pattern_slots.sv
bench/tb.sv
